[hdl/per_task_watchdog_monitor_defines.svh]
// Assertion macros shared by the watchdog monitor RTL.
`ifndef PER_TASK_WATCHDOG_MONITOR_DEFINES_SVH
`define PER_TASK_WATCHDOG_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define PWDM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("watchdog monitor: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define PWDM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("watchdog monitor: next-cycle check failed");

`endif

[hdl/pwdm_pkg.sv]
// Types and constants of the per-task watchdog monitor.
package pwdm_pkg;

	localparam int NUM_SLOTS     = 16;
	localparam int SCAN_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLOT_ID_W     = 4;
	localparam int TICK_W        = 32;
	localparam int COUNT_W       = 32;
	localparam int CMD_W         = 2;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd10000;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [SLOT_ID_W-1:0] slot_id;
	} in_word_t;

	typedef struct packed {
		logic [SLOT_ID_W-1:0] slot_index;
		logic [TICK_W-1:0]    age_ticks;
		logic                 expired;
		logic [COUNT_W-1:0]   touch_count;
		logic                 last_of_scan;
	} out_word_t;

	typedef struct packed {
		logic                registered;
		logic [TICK_W-1:0]   last_tick;
		logic [COUNT_W-1:0]  touch_count;
	} cell_data_t;

	typedef struct packed {
		logic touch;
		logic shift;
	} cell_ctrl_t;

endpackage

[hdl/pwdm_cell.sv]
// One slot cell of the watchdog chain: holds a slot's state and passes it on during a scan.
module pwdm_cell import pwdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [TICK_W-1:0] tick_now,
	input  cell_data_t        next_data,
	output cell_data_t        data
);

	logic                registered_q;
	logic [TICK_W-1:0]   last_tick_q;
	logic [COUNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			registered_q <= 1'b0;
		end else if (ctrl.shift) begin
			registered_q <= next_data.registered;
		end else if (ctrl.touch) begin
			registered_q <= 1'b1;
		end
	end

	// An unregistered slot counts from zero, so its first touch gives a count of one.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			last_tick_q <= next_data.last_tick;
			count_q     <= next_data.touch_count;
		end else if (ctrl.touch) begin
			last_tick_q <= tick_now;
			count_q     <= registered_q ? count_q + COUNT_W'(1) : COUNT_W'(1);
		end
	end

	assign data.registered  = registered_q;
	assign data.last_tick   = last_tick_q;
	assign data.touch_count = count_q;

endmodule

[hdl/pwdm_result.sv]
// Result stage: works out age and expiry for the cell at the head of the chain.
module pwdm_result import pwdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [SCAN_W-1:0] index,
	input  logic              last,
	input  cell_data_t        head,
	input  logic [TICK_W-1:0] tick_now,
	input  logic [TICK_W-1:0] timeout,
	output logic              strobe,
	output out_word_t         word
);

	logic [TICK_W-1:0] age;
	logic              strobe_q;
	out_word_t         word_q;

	assign age = tick_now - head.last_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			word_q.slot_index   <= SLOT_ID_W'(index);
			word_q.age_ticks    <= age;
			word_q.expired      <= (age > timeout);
			word_q.touch_count  <= head.touch_count;
			word_q.last_of_scan <= last;
		end
	end

	assign strobe = strobe_q;
	assign word   = word_q;

endmodule

[hdl/per_task_watchdog_monitor.sv]
// Tick and touch requests are registered; a check holds busy while the chain scans its NUM_SLOTS slots.
// The chain rotates one slot per cycle past the result stage, and a new request is only
// accepted once busy has dropped at the end of the scan.
// Each result appears in the cycle after its slot reaches the head, one per strobe.
// The receiver cannot stall; results are never held back.
// Reset (arst_n low) clears tick count, registration bits and sets the timeout to 10000.
`include "per_task_watchdog_monitor_defines.svh"

module per_task_watchdog_monitor import pwdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_word_t          request,
	input  logic              cfg_wr_en,
	input  logic [TICK_W-1:0] cfg_wr_data,
	output logic              result_strobe,
	output out_word_t         result
);

	logic [TICK_W-1:0]    tick_now_q;
	logic [TICK_W-1:0]    timeout_q;
	logic                 scan_active_q;
	logic [SCAN_W-1:0]    scan_cnt_q;
	logic [NUM_SLOTS-1:0] mask_q;
	logic [NUM_SLOTS-1:0] reg_bits;
	logic                 accept;
	logic                 scan_last;
	logic [NUM_SLOTS-1:0] mask_rest;
	cell_data_t           cell_data [NUM_SLOTS];

	assign accept    = start && !scan_active_q;
	assign busy      = scan_active_q;
	assign scan_last = (scan_cnt_q == SCAN_W'(NUM_SLOTS - 1));
	assign mask_rest = mask_q >> 1;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
			cell_ctrl_t ctrl;
			assign ctrl.shift = scan_active_q;
			assign ctrl.touch = accept && (request.command == CMD_TOUCH)
				&& (32'(request.slot_id) == 32'(gi));
			assign reg_bits[gi] = cell_data[gi].registered;

			pwdm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.tick_now  (tick_now_q),
				.next_data (cell_data[(gi + 1) % NUM_SLOTS]),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now_q    <= '0;
			scan_active_q <= 1'b0;
			scan_cnt_q    <= '0;
			mask_q        <= '0;
		end else if (scan_active_q) begin
			// The mask shifts with the chain, so bit zero always belongs to the head cell.
			mask_q     <= mask_rest;
			scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
			if (scan_last) begin
				scan_active_q <= 1'b0;
			end
		end else if (accept) begin
			case (request.command)
				CMD_TICK: begin
					tick_now_q <= tick_now_q + TICK_W'(1);
				end
				CMD_CHECK: begin
					scan_active_q <= 1'b1;
					scan_cnt_q    <= '0;
					mask_q        <= reg_bits;
				end
				default: begin
				end
			endcase
		end
	end

	pwdm_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (scan_active_q && cell_data[0].registered),
		.index    (scan_cnt_q),
		.last     (mask_rest == '0),
		.head     (cell_data[0]),
		.tick_now (tick_now_q),
		.timeout  (timeout_q),
		.strobe   (result_strobe),
		.word     (result)
	);

	`PWDM_ASSERT_NXT(a_no_word_outside_scan, !busy, !result_strobe)
	`PWDM_ASSERT_NXT(a_check_starts_scan, start && !busy && request.command == CMD_CHECK, busy)
	`PWDM_ASSERT_NXT(a_nothing_after_last, result_strobe && result.last_of_scan, !result_strobe)
	`PWDM_ASSERT_IMP(a_mask_tracks_head, busy, mask_q[0] == cell_data[0].registered)

endmodule
